@@ rtl/fbc_pkg.sv @@
`default_nettype none

package fbc_pkg;

    // Field and register widths.
    localparam int COORD_W      = 32;
    localparam int ENTRY_W      = 32;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 4;
    localparam int NUM_CFG_REGS = 8;
    localparam int NUM_PLANES   = 6;
    localparam int NUM_AXES     = 3;

    // A plane component is the sum or difference of two matrix entries.
    localparam int COMP_W = ENTRY_W + 1;
    // Product of a plane component and a coordinate, exact.
    localparam int PROD_W = COMP_W + COORD_W;
    // Offset plus three products, exact.
    localparam int ACC_W  = PROD_W + 2;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    // Matrix registers come out of reset as the identity matrix.
    localparam logic [CFG_DATA_W-1:0] MAT_RESET [NUM_CFG_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COMP_W-1:0]  comp_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    // One frustum plane: normal (x, y, z) and offset w.
    typedef struct packed {
        comp_t nx;
        comp_t ny;
        comp_t nz;
        comp_t w;
    } plane_t;

    typedef plane_t [NUM_PLANES-1:0] plane_set_t;

    // One box as min and max corners.
    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_t;

endpackage

`default_nettype wire

@@ rtl/fbc_cfg_regs.sv @@
`default_nettype none

// Matrix register file and plane extraction. The six planes are row 3 of
// the matrix plus or minus rows 0, 1 and 2, formed per column.
module fbc_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    input  wire logic [fbc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [fbc_pkg::CFG_DATA_W-1:0]       cfg_data,
    output fbc_pkg::plane_set_t                       planes
);

    logic [fbc_pkg::CFG_DATA_W-1:0] mat_reg [fbc_pkg::NUM_CFG_REGS];
    logic                           wr_en;
    // Matrix entries as [column][row].
    logic signed [fbc_pkg::ENTRY_W-1:0] elem [4][4];
    fbc_pkg::comp_t                     comp [fbc_pkg::NUM_PLANES][4];

    // Writes beyond the last register are dropped.
    assign wr_en = cfg_valid
        && (cfg_index < fbc_pkg::CFG_IDX_W'(fbc_pkg::NUM_CFG_REGS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fbc_pkg::NUM_CFG_REGS; i++)
            begin
                mat_reg[i] <= fbc_pkg::MAT_RESET[i];
            end
        end
        else if (wr_en)
        begin
            mat_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Unpack the registers: low word holds the even row, high word the odd row.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            elem[c][0] = mat_reg[2 * c][fbc_pkg::ENTRY_W-1:0];
            elem[c][1] = mat_reg[2 * c][fbc_pkg::CFG_DATA_W-1:fbc_pkg::ENTRY_W];
            elem[c][2] = mat_reg[2 * c + 1][fbc_pkg::ENTRY_W-1:0];
            elem[c][3] = mat_reg[2 * c + 1][fbc_pkg::CFG_DATA_W-1:fbc_pkg::ENTRY_W];
        end
    end

    // Even planes add row k to row 3, odd planes subtract it.
    always_comb
    begin
        for (int p = 0; p < fbc_pkg::NUM_PLANES; p++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if ((p % 2) == 1)
                begin
                    comp[p][c] = fbc_pkg::comp_t'(elem[c][3]) - fbc_pkg::comp_t'(elem[c][p / 2]);
                end
                else
                begin
                    comp[p][c] = fbc_pkg::comp_t'(elem[c][3]) + fbc_pkg::comp_t'(elem[c][p / 2]);
                end
            end
            planes[p].nx = comp[p][0];
            planes[p].ny = comp[p][1];
            planes[p].nz = comp[p][2];
            planes[p].w  = comp[p][3];
        end
    end

    // A write to an index past the register file changes nothing.
    a_ignore_out_of_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cfg_valid && !wr_en) |=> $stable(planes)
    ) else $error("out-of-range register write changed the planes");

endmodule

`default_nettype wire

@@ rtl/fbc_cull_pipe.sv @@
`default_nettype none

// Four-stage cull pipeline: capture, corner select and multiply, partial
// sum, final sum with sign test into the output register.
module fbc_cull_pipe #(
    parameter int FRAC_BITS = fbc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fbc_pkg::plane_set_t planes,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire fbc_pkg::box_t       box,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     visible
);

    localparam int NP = fbc_pkg::NUM_PLANES;
    localparam int NA = fbc_pkg::NUM_AXES;
    localparam int EXT_W = fbc_pkg::ACC_W - fbc_pkg::COMP_W - FRAC_BITS;

    // Per-stage valid bits and advance enables.
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic en1, en2, en3, en_out;

    fbc_pkg::box_t  box_reg;
    fbc_pkg::prod_t prod_reg [NP][NA];
    fbc_pkg::prod_t prod_next [NP][NA];
    fbc_pkg::acc_t  woff_reg [NP];
    fbc_pkg::acc_t  woff_next [NP];
    fbc_pkg::acc_t  part_reg [NP];
    fbc_pkg::acc_t  part_next [NP];
    fbc_pkg::prod_t pz_reg [NP];
    logic           visible_reg;
    logic           visible_next;
    fbc_pkg::coord_t corner [NP][NA];
    fbc_pkg::comp_t  ncomp [NP][NA];

    // A stage loads when it is empty or its contents move on.
    assign en_out   = !out_valid_reg || !out_stall;
    assign en3      = !v3_reg || en_out;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    // Stage 1: capture the box.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            box_reg <= box;
        end
    end

    // Stage 2: pick the corner farthest along each normal and multiply.
    always_comb
    begin
        for (int p = 0; p < NP; p++)
        begin
            ncomp[p][0] = planes[p].nx;
            ncomp[p][1] = planes[p].ny;
            ncomp[p][2] = planes[p].nz;
            corner[p][0] = ncomp[p][0][fbc_pkg::COMP_W-1] ? box_reg.min_x : box_reg.max_x;
            corner[p][1] = ncomp[p][1][fbc_pkg::COMP_W-1] ? box_reg.min_y : box_reg.max_y;
            corner[p][2] = ncomp[p][2][fbc_pkg::COMP_W-1] ? box_reg.min_z : box_reg.max_z;
            for (int a = 0; a < NA; a++)
            begin
                prod_next[p][a] = fbc_pkg::prod_t'(ncomp[p][a]) * fbc_pkg::prod_t'(corner[p][a]);
            end
            // Offset scaled up to the product format.
            woff_next[p] = {{EXT_W{planes[p].w[fbc_pkg::COMP_W-1]}}, planes[p].w,
                            {FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            prod_reg <= prod_next;
            woff_reg <= woff_next;
        end
    end

    // Stage 3: offset plus the x and y terms; z term carried along.
    always_comb
    begin
        for (int p = 0; p < NP; p++)
        begin
            part_next[p] = woff_reg[p] + fbc_pkg::acc_t'(prod_reg[p][0])
                         + fbc_pkg::acc_t'(prod_reg[p][1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            part_reg <= part_next;
            for (int p = 0; p < NP; p++)
            begin
                pz_reg[p] <= prod_reg[p][2];
            end
        end
    end

    // Stage 4: the box is visible unless some plane sum is negative.
    always_comb
    begin
        fbc_pkg::acc_t total;
        visible_next = 1'b1;
        for (int p = 0; p < NP; p++)
        begin
            total = part_reg[p] + fbc_pkg::acc_t'(pz_reg[p]);
            if (total[fbc_pkg::ACC_W-1])
            begin
                visible_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            visible_reg <= visible_next;
        end
    end

    // Input is held back only when every stage is full and the output waits.
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && out_valid_reg && out_stall)
    ) else $error("input stalled while the pipeline had room");

    // A new result comes only from an item in the last inner stage.
    a_result_source: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v3_reg)
    ) else $error("result appeared without an item behind it");

    // A taken result with nothing behind it leaves the output empty.
    a_drain: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !v3_reg) |=> !out_valid_reg
    ) else $error("result repeated after it was taken");

endmodule

`default_nettype wire

@@ rtl/frustum_box_cull_core.sv @@
`default_nettype none

// Frustum culling of axis-aligned boxes. Each item is a box given by min and
// max corners in signed fixed point; the result is one bit, visible, which is
// 0 when some plane of the view frustum has the whole box on its outer side.
// The six planes come from the configured 4x4 matrix (row 3 plus or minus
// rows 0..2) and all sums and products are exact, so no rounding affects the
// answer. The pipeline takes one box per cycle unless in_stall is raised
// (every stage full and the output stalled); a result moves through the
// capture, multiply, partial sum and output registers in turn. The four
// register stages are one capture stage, one multiply stage with eighteen
// 33x32 multipliers, one partial sum stage and the final sum feeding the
// output register. Matrix writes must only be made while no box is in
// flight; cfg_ready is always high and writes to indexes above 7 are ignored.
module frustum_box_cull_core #(
    parameter int FRAC_BITS = fbc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fbc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic signed [fbc_pkg::COORD_W-1:0] min_x,
    input  wire logic signed [fbc_pkg::COORD_W-1:0] min_y,
    input  wire logic signed [fbc_pkg::COORD_W-1:0] min_z,
    input  wire logic signed [fbc_pkg::COORD_W-1:0] max_x,
    input  wire logic signed [fbc_pkg::COORD_W-1:0] max_y,
    input  wire logic signed [fbc_pkg::COORD_W-1:0] max_z,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 visible
);

    fbc_pkg::plane_set_t planes;
    fbc_pkg::box_t       box;

    assign cfg_ready = 1'b1;

    // Bundle the box fields for the pipeline.
    assign box.min_x = min_x;
    assign box.min_y = min_y;
    assign box.min_z = min_z;
    assign box.max_x = max_x;
    assign box.max_y = max_y;
    assign box.max_z = max_z;

    fbc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes)
    );

    fbc_cull_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cull_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .planes    (planes),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .box       (box),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .visible   (visible)
    );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`default_nettype none

module testbench;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int FRAC          = 16;
    localparam int NUM_MAT_COLS  = 4;
    localparam int W_ROW         = 3;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 100;
    localparam int MAX_REPORTS   = 40;

    localparam fbc_pkg::coord_t ONE       = 32'sh0001_0000;
    localparam fbc_pkg::coord_t HALF      = 32'sh0000_8000;
    localparam fbc_pkg::coord_t MOST_NEG  = 32'sh8000_0000;
    localparam fbc_pkg::coord_t MOST_POS  = 32'sh7fff_ffff;
    localparam fbc_pkg::coord_t NEAR_SPAN = 32'sh0003_0000;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_RARE
    } stall_mode_t;

    // One expected verdict together with the box that produced it.
    typedef struct packed {
        fbc_pkg::box_t box;
        logic seen;
    } cull_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [fbc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [fbc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    fbc_pkg::coord_t min_x = '0;
    fbc_pkg::coord_t min_y = '0;
    fbc_pkg::coord_t min_z = '0;
    fbc_pkg::coord_t max_x = '0;
    fbc_pkg::coord_t max_y = '0;
    fbc_pkg::coord_t max_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic visible;

    fbc_pkg::box_t pending_boxes[$];
    cull_result_t expected_verdicts[$];
    logic [fbc_pkg::CFG_DATA_W-1:0] mat_model[fbc_pkg::NUM_CFG_REGS];
    logic [fbc_pkg::CFG_DATA_W-1:0] next_mat[fbc_pkg::NUM_CFG_REGS];
    fbc_pkg::box_t next_box;
    fbc_pkg::box_t taken_box;
    cull_result_t oldest;
    int mismatch_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int stall_timer = 0;
    int unsigned cycle_count = 0;

    frustum_box_cull_core #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .min_x(min_x),
        .min_y(min_y),
        .min_z(min_z),
        .max_x(max_x),
        .max_y(max_y),
        .max_z(max_z),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .visible(visible)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Signed matrix entry at (col, row) from the shadow registers.
    function automatic logic signed [63:0] mat_entry(input int col, input int row);
        logic [fbc_pkg::CFG_DATA_W-1:0] word;
        logic signed [fbc_pkg::ENTRY_W-1:0] entry;
        word = mat_model[2 * col + row / 2];
        entry = (row % 2 == 1) ? word[63:32] : word[31:0];
        return entry;
    endfunction

    // Exact plane test: the box survives unless some plane puts its farthest
    // corner strictly behind it. Entry sums are held at 64 bits and products and
    // the accumulator at 128 bits, so no sum or product can wrap.
    function automatic logic box_in_frustum(input fbc_pkg::box_t b);
        logic signed [63:0] base;
        logic signed [63:0] other;
        logic signed [63:0] sum;
        logic signed [127:0] acc;
        logic signed [127:0] comp;
        logic signed [127:0] crd;
        fbc_pkg::coord_t pick;
        logic seen;
        seen = 1'b1;
        for (int p = 0; p < fbc_pkg::NUM_PLANES; p++)
        begin
            acc = '0;
            for (int c = 0; c < NUM_MAT_COLS; c++)
            begin
                base  = mat_entry(c, W_ROW);
                other = mat_entry(c, p / 2);
                sum   = (p % 2 == 1) ? base - other : base + other;
                comp  = sum;
                if (c == W_ROW)
                begin
                    acc = acc + (comp <<< FRAC);
                end
                else
                begin
                    case (c)
                        0: pick = (sum >= 0) ? b.max_x : b.min_x;
                        1: pick = (sum >= 0) ? b.max_y : b.min_y;
                        default: pick = (sum >= 0) ? b.max_z : b.min_z;
                    endcase
                    crd = pick;
                    acc = acc + comp * crd;
                end
            end
            if (acc < 0)
                seen = 1'b0;
        end
        return seen;
    endfunction

    function automatic fbc_pkg::coord_t rand_coord(input bit full_range);
        int unsigned sel;
        sel = $urandom_range(0, 31);
        if (sel == 0)
            return MOST_NEG;
        if (sel == 1)
            return MOST_POS;
        if (sel == 2)
            return '0;
        if (full_range || sel == 3)
            return $urandom;
        return $urandom_range(0, 2 * NEAR_SPAN) - NEAR_SPAN;
    endfunction

    // Entries near a real projection most of the time: small axis rows and a
    // positive w term, so the verdict goes both ways.
    function automatic logic [fbc_pkg::ENTRY_W-1:0] rand_entry(input bit full_range,
                                                              input int col,
                                                              input int row);
        int unsigned sel;
        sel = $urandom_range(0, 63);
        if (sel == 0)
            return MOST_NEG;
        if (sel == 1)
            return MOST_POS;
        if (sel == 2)
            return '0;
        if (full_range)
            return $urandom;
        if (row == W_ROW && col == W_ROW)
            return $urandom_range(HALF, 4 * ONE);
        if (row == W_ROW)
            return $urandom_range(0, ONE) - HALF;
        return $urandom_range(0, 2 * ONE) - ONE;
    endfunction

    task automatic set_entry(input int col, input int row,
                             input logic [fbc_pkg::ENTRY_W-1:0] val);
        if (row % 2 == 1)
            next_mat[2 * col + row / 2][63:32] = val;
        else
            next_mat[2 * col + row / 2][31:0] = val;
    endtask

    task automatic queue_box(input fbc_pkg::coord_t lx, input fbc_pkg::coord_t ly,
                             input fbc_pkg::coord_t lz, input fbc_pkg::coord_t hx,
                             input fbc_pkg::coord_t hy, input fbc_pkg::coord_t hz);
        fbc_pkg::box_t b;
        b = {lx, ly, lz, hx, hy, hz};
        pending_boxes.push_back(b);
    endtask

    // Mostly ordered boxes; now and then min and max are left swapped.
    task automatic queue_random_box(input bit full_range);
        fbc_pkg::coord_t lo[3];
        fbc_pkg::coord_t hi[3];
        fbc_pkg::coord_t swap;
        bit inverted;
        inverted = ($urandom_range(0, 9) == 0);
        for (int a = 0; a < 3; a++)
        begin
            lo[a] = rand_coord(full_range);
            hi[a] = rand_coord(full_range);
            if (!inverted && lo[a] > hi[a])
            begin
                swap = lo[a];
                lo[a] = hi[a];
                hi[a] = swap;
            end
        end
        queue_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endtask

    task automatic queue_extreme_boxes();
        queue_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS);
        queue_box(MOST_POS, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, MOST_NEG);
    endtask

    task automatic wait_drained();
        while (pending_boxes.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [fbc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx[fbc_pkg::CFG_IDX_W-1:0];
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Writes all matrix registers in a rotated order, with one write to an
    // unused index slipped in somewhere.
    task automatic apply_matrix();
        int first;
        int junk_slot;
        int k;
        first = $urandom_range(0, fbc_pkg::NUM_CFG_REGS - 1);
        junk_slot = $urandom_range(0, fbc_pkg::NUM_CFG_REGS);
        k = 0;
        @(posedge clk);
        for (int n = 0; n <= fbc_pkg::NUM_CFG_REGS; n++)
        begin
            if (n == junk_slot)
            begin
                write_reg(fbc_pkg::NUM_CFG_REGS
                          + $urandom_range(0, fbc_pkg::NUM_CFG_REGS - 1),
                          {$urandom, $urandom});
            end
            else
            begin
                write_reg((first + k) % fbc_pkg::NUM_CFG_REGS,
                          next_mat[(first + k) % fbc_pkg::NUM_CFG_REGS]);
                k++;
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // Sender: bursts of items separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0 || pending_boxes.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                next_box = pending_boxes.pop_front();
                min_x <= next_box.min_x;
                min_y <= next_box.min_y;
                min_z <= next_box.min_z;
                max_x <= next_box.max_x;
                max_y <= next_box.max_y;
                max_z <= next_box.max_z;
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Receiver: the stall pattern switches between a few modes over time.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            cycle_count++;
            if (stall_timer == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_RARE));
                stall_timer = $urandom_range(20, 120);
            end
            else
            begin
                stall_timer--;
            end
            case (stall_mode)
                STALL_NONE: out_stall <= 1'b0;
                STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
                STALL_PERIODIC: out_stall <= ((cycle_count % 7) < 3);
                default: out_stall <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Shadow of the matrix registers and the verdict for every accepted item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fbc_pkg::NUM_CFG_REGS; i++)
                mat_model[i] = '0;
            for (int c = 0; c < NUM_MAT_COLS; c++)
                mat_model[2 * c + c / 2] = (c % 2 == 1) ? {ONE, 32'h0} : {32'h0, ONE};
            expected_verdicts.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index < fbc_pkg::NUM_CFG_REGS)
                mat_model[cfg_index[2:0]] = cfg_data;
            if (in_valid && !in_stall)
            begin
                taken_box = {min_x, min_y, min_z, max_x, max_y, max_z};
                expected_verdicts.push_back({taken_box, box_in_frustum(taken_box)});
            end
        end
    end

    // Compare each accepted result with the oldest outstanding verdict.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("visible %b with no box outstanding", visible));
            end
            else
            begin
                oldest = expected_verdicts.pop_front();
                if (visible !== oldest.seen)
                    report_mismatch($sformatf("box %h: visible %b, predicted %b",
                                              oldest.box, visible, oldest.seen));
            end
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Identity matrix out of reset: inside, outside each slab, on the
        // boundary and one step past it, extremes and an inverted box.
        queue_box(-HALF, -HALF, -HALF, HALF, HALF, HALF);
        queue_box(2 * ONE, -HALF, -HALF, 3 * ONE, HALF, HALF);
        queue_box(-3 * ONE, -HALF, -HALF, -2 * ONE, HALF, HALF);
        queue_box(-HALF, 2 * ONE, -HALF, HALF, 3 * ONE, HALF);
        queue_box(-HALF, -HALF, -3 * ONE, HALF, HALF, -2 * ONE);
        queue_box(-2 * ONE, -HALF, -HALF, -ONE, HALF, HALF);
        queue_box(-2 * ONE, -HALF, -HALF, -ONE - 1, HALF, HALF);
        queue_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS);
        queue_box(MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS);
        queue_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
        queue_box('0, '0, '0, '0, '0, '0);
        queue_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
        queue_box(-1, -1, -1, -1, -1, -1);
        wait_drained();

        // All-zero matrix: every plane has a zero normal and a zero offset.
        for (int i = 0; i < fbc_pkg::NUM_CFG_REGS; i++)
            next_mat[i] = '0;
        apply_matrix();
        queue_extreme_boxes();
        wait_drained();

        // Zero normals with a negative offset reject everything.
        set_entry(W_ROW, W_ROW, -ONE);
        apply_matrix();
        queue_box(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, MOST_POS);
        wait_drained();

        // Extreme entries give the widest plane components.
        for (int i = 0; i < fbc_pkg::NUM_CFG_REGS; i++)
            next_mat[i] = {MOST_NEG, MOST_NEG};
        apply_matrix();
        queue_extreme_boxes();
        wait_drained();
        for (int i = 0; i < fbc_pkg::NUM_CFG_REGS; i++)
            next_mat[i] = {MOST_POS, MOST_POS};
        apply_matrix();
        queue_extreme_boxes();
        wait_drained();
        for (int c = 0; c < NUM_MAT_COLS; c++)
            for (int r = 0; r < NUM_MAT_COLS; r++)
                set_entry(c, r, (r == W_ROW) ? MOST_POS : MOST_NEG);
        apply_matrix();
        queue_extreme_boxes();

        // Random phases, each under a fresh matrix once the pipeline is empty.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            if (ph == 0)
            begin
                for (int i = 0; i < fbc_pkg::NUM_CFG_REGS; i++)
                    next_mat[i] = '0;
                for (int c = 0; c < NUM_MAT_COLS; c++)
                    set_entry(c, c, ONE);
            end
            else
            begin
                for (int c = 0; c < NUM_MAT_COLS; c++)
                    for (int r = 0; r < NUM_MAT_COLS; r++)
                        set_entry(c, r, rand_entry(ph % 4 == 3, c, r));
            end
            apply_matrix();
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_random_box(ph == 5 || $urandom_range(0, 7) == 0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/fbc_pkg.sv
rtl/fbc_cfg_regs.sv
rtl/fbc_cull_pipe.sv
rtl/frustum_box_cull_core.sv
tb/sv/testbench.sv
